### rtl/mkpc_pkg.sv
// shared types and constants of the multi-key press classifier
package mkpc_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned LevelW = 6;
  localparam int unsigned KeyIdxW = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0] DebounceReset = 16'd3;
  localparam logic [CountW-1:0] LongPressReset = 16'd100;
  localparam logic [CountW-1:0] RepeatReset = 16'd20;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD     = 2'd2,
    PH_REPEAT   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    EV_PRESS         = 3'd0,
    EV_SHORT_RELEASE = 3'd1,
    EV_LONG_PRESS    = 3'd2,
    EV_REPEAT        = 3'd3,
    EV_LONG_RELEASE  = 3'd4
  } event_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_REPEAT     = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_index_e;

  // timing registers as seen by every key
  typedef struct packed {
    logic [CountW-1:0] debounce_ticks;
    logic [CountW-1:0] long_press_ticks;
    logic [CountW-1:0] repeat_ticks;
  } cfg_t;

endpackage

### rtl/mkpc_key.sv
// per-key phase machine with debounce, long press and repeat counters
module mkpc_key (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 down_i,
  input  mkpc_pkg::cfg_t       cfg_i,
  output logic                 ev_valid_o,
  output mkpc_pkg::event_kind_e ev_kind_o
);
  import mkpc_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] deb_q, deb_d;
  logic [CountW-1:0] long_q, long_d;
  logic [CountW-1:0] rep_q, rep_d;
  logic [CountW-1:0] deb_dec, long_dec, rep_dec;

  assign deb_dec  = deb_q - 1'b1;
  assign long_dec = long_q - 1'b1;
  assign rep_dec  = rep_q - 1'b1;

  // next phase, counters and event for one scan tick
  always_comb begin
    phase_d    = phase_q;
    deb_d      = deb_q;
    long_d     = long_q;
    rep_d      = rep_q;
    ev_valid_o = 1'b0;
    ev_kind_o  = EV_PRESS;
    unique case (phase_q)
      PH_IDLE: begin
        if (down_i) phase_d = PH_DEBOUNCE;
      end
      PH_DEBOUNCE: begin
        if (!down_i) begin
          deb_d   = cfg_i.debounce_ticks;
          phase_d = PH_IDLE;
        end else if (deb_dec == '0) begin
          deb_d      = cfg_i.debounce_ticks;
          phase_d    = PH_HELD;
          ev_valid_o = 1'b1;
          ev_kind_o  = EV_PRESS;
        end else begin
          deb_d = deb_dec;
        end
      end
      PH_HELD: begin
        if (!down_i) begin
          long_d     = cfg_i.long_press_ticks;
          phase_d    = PH_IDLE;
          ev_valid_o = 1'b1;
          ev_kind_o  = EV_SHORT_RELEASE;
        end else if (long_dec == '0) begin
          long_d     = cfg_i.long_press_ticks;
          phase_d    = PH_REPEAT;
          ev_valid_o = 1'b1;
          ev_kind_o  = EV_LONG_PRESS;
        end else begin
          long_d = long_dec;
        end
      end
      PH_REPEAT: begin
        if (!down_i) begin
          rep_d      = cfg_i.repeat_ticks;
          phase_d    = PH_IDLE;
          ev_valid_o = 1'b1;
          ev_kind_o  = EV_LONG_RELEASE;
        end else if (rep_dec == '0) begin
          rep_d      = cfg_i.repeat_ticks;
          ev_valid_o = 1'b1;
          ev_kind_o  = EV_REPEAT;
        end else begin
          rep_d = rep_dec;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // state registers advance only on an accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      deb_q   <= DebounceReset;
      long_q  <= LongPressReset;
      rep_q   <= RepeatReset;
    end else if (step_i) begin
      phase_q <= phase_d;
      deb_q   <= deb_d;
      long_q  <= long_d;
      rep_q   <= rep_d;
    end
  end

endmodule

### rtl/mkpc_serializer.sv
// holds one tick's events and sends them out in key order, one per cycle while the output is not stalled
module mkpc_serializer #(
  parameter int unsigned KEY_COUNT = 6
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic [KEY_COUNT-1:0]                  ev_mask_i,
  input  mkpc_pkg::event_kind_e [KEY_COUNT-1:0] ev_kind_i,
  output logic                                  free_o,
  output logic [KEY_COUNT-1:0]                  pend_mask_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [mkpc_pkg::KeyIdxW-1:0]          key_index_o,
  output mkpc_pkg::event_kind_e                 event_kind_o,
  output logic                                  last_of_tick_o
);
  import mkpc_pkg::*;

  localparam int unsigned IdxW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  logic [KEY_COUNT-1:0]              mask_q, mask_d;
  event_kind_e [KEY_COUNT-1:0]       kind_q, kind_d;
  logic                              valid_q, valid_d;
  logic [KeyIdxW-1:0]                key_q, key_d;
  event_kind_e                       ev_q, ev_d;
  logic                              last_q, last_d;
  logic [IdxW-1:0]                   sel;
  logic                              out_load;
  logic                              take;

  // lowest pending key
  always_comb begin
    sel = '0;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (mask_q[k]) sel = IdxW'(k);
    end
  end

  assign out_load = !valid_q || !out_stall_i;
  assign take     = out_load && (mask_q != '0);
  assign free_o   = (mask_q == '0) || ($onehot(mask_q) && out_load);

  // pending set and output register
  always_comb begin
    mask_d  = mask_q;
    kind_d  = kind_q;
    valid_d = valid_q;
    key_d   = key_q;
    ev_d    = ev_q;
    last_d  = last_q;
    if (take) begin
      mask_d  = mask_q & (mask_q - 1'b1);
      valid_d = 1'b1;
      key_d   = KeyIdxW'(sel);
      ev_d    = kind_q[sel];
      last_d  = $onehot(mask_q);
    end else if (out_load) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      mask_d = ev_mask_i;
      kind_d = ev_kind_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      mask_q  <= mask_d;
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    key_q  <= key_d;
    ev_q   <= ev_d;
    last_q <= last_d;
  end

  assign pend_mask_o    = mask_q;
  assign out_valid_o    = valid_q;
  assign key_index_o    = key_q;
  assign event_kind_o   = ev_q;
  assign last_of_tick_o = last_q;

endmodule

### rtl/multi_key_press_classifier.sv
// top level: key debounce, long press and auto-repeat classifier
//
// Input channel: one request per scan tick carrying pressed_levels_i, bit k
// high while key k is down. Every key machine advances on the accepted tick.
// Output channel: one request per event, key_index_o and event_kind_o, with
// last_of_tick_o set on the final event of a tick; events of a tick come in
// ascending key order. A tick with no event produces no request.
// Config channel: write debounce, long press and repeat tick counts by index
// while the block is idle; cfg_ready_o is always high, unknown indexes drop.
// The events of an accepted tick are registered into the pending event set,
// and the first of them then moves into the single output register.
// Throughput: the output register drains the pending event set one per cycle
// while the output is not stalled, and the input stalls while more than one
// event is pending; ticks without events are taken every cycle while none is pending.
// Reset: all keys idle, counters and timing registers at 3, 100 and 20.
// A stalled output holds its request; while it is held the input stalls
// whenever any event of the current tick is still pending.
module multi_key_press_classifier #(
  parameter int unsigned KEY_COUNT = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mkpc_pkg::LevelW-1:0]    pressed_levels_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mkpc_pkg::KeyIdxW-1:0]   key_index_o,
  output logic [2:0]                     event_kind_o,
  output logic                           last_of_tick_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mkpc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mkpc_pkg::CountW-1:0]    cfg_data_i
);
  import mkpc_pkg::*;

  cfg_t                        cfg_q;
  logic                        in_accept;
  logic                        free;
  logic [KEY_COUNT-1:0]        ev_mask;
  event_kind_e [KEY_COUNT-1:0] ev_kind;
  logic [KEY_COUNT-1:0]        pend_mask;
  event_kind_e                 kind_out;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !free;
  assign in_accept   = in_valid_i && free;

  // timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DebounceReset;
      cfg_q.long_press_ticks <= LongPressReset;
      cfg_q.repeat_ticks     <= RepeatReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_DEBOUNCE:   cfg_q.debounce_ticks   <= cfg_data_i;
        CFG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data_i;
        CFG_REPEAT:     cfg_q.repeat_ticks     <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // one phase machine per key
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
    logic down;
    if (k < LevelW) begin : g_wired
      assign down = pressed_levels_i[k];
    end else begin : g_absent
      assign down = 1'b0;
    end
    mkpc_key u_key (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (in_accept),
      .down_i     (down),
      .cfg_i      (cfg_q),
      .ev_valid_o (ev_mask[k]),
      .ev_kind_o  (ev_kind[k])
    );
  end

  // event serializer
  mkpc_serializer #(
    .KEY_COUNT (KEY_COUNT)
  ) u_ser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (in_accept),
    .ev_mask_i      (ev_mask),
    .ev_kind_i      (ev_kind),
    .free_o         (free),
    .pend_mask_o    (pend_mask),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_index_o    (key_index_o),
    .event_kind_o   (kind_out),
    .last_of_tick_o (last_of_tick_o)
  );

  assign event_kind_o = kind_out;

  // pending events stay put while the output register is blocked
  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_mask != '0 && out_valid_o && out_stall_i) |=> pend_mask == $past(pend_mask))
    else $error("pending events changed while output blocked");

  // an event that is not the last of its tick has followers pending
  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_tick_o) |-> pend_mask != '0)
    else $error("non-last event without pending followers");

  // no tick is taken while more than one event is still pending
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (pend_mask == '0 || $onehot(pend_mask)))
    else $error("tick accepted over pending events");

endmodule

### dv/testbench.sv
// self-checking testbench for the multi-key press classifier
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mkpc_pkg::*;

  localparam int unsigned KeyCount = 6;

  // one expected event on the output channel
  typedef struct packed {
    logic [KeyIdxW-1:0] key;
    event_kind_e        kind;
    logic               last;
  } key_event_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [LevelW-1:0]   pressed_levels_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [KeyIdxW-1:0]  key_index_o;
  logic [2:0]          event_kind_o;
  logic                last_of_tick_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CountW-1:0]   cfg_data_i = '0;

  multi_key_press_classifier #(
    .KEY_COUNT(KeyCount)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pressed_levels_i (pressed_levels_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .key_index_o      (key_index_o),
    .event_kind_o     (event_kind_o),
    .last_of_tick_o   (last_of_tick_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // scan ticks waiting to be sent, key events waiting to come out
  logic [LevelW-1:0] scan_ticks [$];
  key_event_t        pending_events [$];
  key_event_t        oldest_event;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;

  // shadow of the timing registers and of every key machine
  cfg_t              timing;
  phase_e            key_ph [KeyCount];
  logic [CountW-1:0] db_left [KeyCount];
  logic [CountW-1:0] lp_left [KeyCount];
  logic [CountW-1:0] rp_left [KeyCount];

  // per-key level runs for the random ticks
  bit run_level [KeyCount];
  int run_left [KeyCount];

  task automatic report_error(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void reset_keys();
    timing = '{debounce_ticks: DebounceReset, long_press_ticks: LongPressReset,
               repeat_ticks: RepeatReset};
    for (int k = 0; k < KeyCount; k++) begin
      key_ph[k] = PH_IDLE;
      db_left[k] = DebounceReset;
      lp_left[k] = LongPressReset;
      rp_left[k] = RepeatReset;
    end
  endfunction

  // advance every key by one scan tick and queue the events it fires
  function automatic void classify_tick(input logic [LevelW-1:0] levels);
    key_event_t  fired [$];
    event_kind_e kind;
    bit          hit;
    bit          down;
    for (int k = 0; k < KeyCount; k++) begin
      down = levels[k];
      hit = 1'b0;
      kind = EV_PRESS;
      case (key_ph[k])
        PH_IDLE: begin
          if (down) key_ph[k] = PH_DEBOUNCE;
        end
        PH_DEBOUNCE: begin
          if (down) begin
            db_left[k] = db_left[k] - 1'b1;
            if (db_left[k] == '0) begin
              db_left[k] = timing.debounce_ticks;
              key_ph[k] = PH_HELD;
              hit = 1'b1;
              kind = EV_PRESS;
            end
          end else begin
            // bounce: back to idle without an event
            db_left[k] = timing.debounce_ticks;
            key_ph[k] = PH_IDLE;
          end
        end
        PH_HELD: begin
          if (down) begin
            lp_left[k] = lp_left[k] - 1'b1;
            if (lp_left[k] == '0) begin
              lp_left[k] = timing.long_press_ticks;
              key_ph[k] = PH_REPEAT;
              hit = 1'b1;
              kind = EV_LONG_PRESS;
            end
          end else begin
            lp_left[k] = timing.long_press_ticks;
            key_ph[k] = PH_IDLE;
            hit = 1'b1;
            kind = EV_SHORT_RELEASE;
          end
        end
        default: begin
          // repeat counter carries over from the previous repeating phase
          if (down) begin
            rp_left[k] = rp_left[k] - 1'b1;
            if (rp_left[k] == '0) begin
              rp_left[k] = timing.repeat_ticks;
              hit = 1'b1;
              kind = EV_REPEAT;
            end
          end else begin
            rp_left[k] = timing.repeat_ticks;
            key_ph[k] = PH_IDLE;
            hit = 1'b1;
            kind = EV_LONG_RELEASE;
          end
        end
      endcase
      if (hit) fired.push_back('{key: KeyIdxW'(k), kind: kind, last: 1'b0});
    end
    if (fired.size() > 0) fired[fired.size()-1].last = 1'b1;
    foreach (fired[i]) pending_events.push_back(fired[i]);
  endfunction

  // mostly held and released runs per key, some pure noise ticks
  function automatic logic [LevelW-1:0] next_levels();
    logic [LevelW-1:0] lv;
    if ($urandom_range(99) < 10) return LevelW'($urandom_range(63));
    for (int k = 0; k < KeyCount; k++) begin
      if (run_left[k] == 0) begin
        run_level[k] = !run_level[k];
        run_left[k] = run_level[k] ? $urandom_range(1, 14) : $urandom_range(1, 5);
      end
      lv[k] = run_level[k];
      run_left[k]--;
    end
    return lv;
  endfunction

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) classify_tick(pressed_levels_i);
      if (!in_valid_i || !in_stall_o) begin
        if (scan_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          pressed_levels_i <= scan_ticks.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and stall generator
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid_o && !out_stall_i) begin
        if (pending_events.size() == 0) begin
          report_error($sformatf("unexpected event key %0d kind %0d",
                                 key_index_o, event_kind_o));
        end else begin
          oldest_event = pending_events.pop_front();
          if (key_index_o !== oldest_event.key)
            report_error($sformatf("key_index %0d, want %0d", key_index_o, oldest_event.key));
          if (event_kind_o !== oldest_event.kind)
            report_error($sformatf("key %0d event_kind %0d, want %0d", oldest_event.key,
                                   event_kind_o, oldest_event.kind));
          if (last_of_tick_o !== oldest_event.last)
            report_error($sformatf("key %0d last_of_tick %0b, want %0b", oldest_event.key,
                                   last_of_tick_o, oldest_event.last));
        end
      end
    end
  end

  // one register write request; the caller drops valid after the last one
  task automatic write_timing_reg(input cfg_index_e idx, input logic [CountW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DEBOUNCE:   timing.debounce_ticks = value;
      CFG_LONG_PRESS: timing.long_press_ticks = value;
      CFG_REPEAT:     timing.repeat_ticks = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (scan_ticks.size() != 0 || in_valid_i || pending_events.size() != 0)
      @(posedge clk_i);
  endtask

  // retime the block while idle, then send random ticks in bursts
  task automatic run_phase(input int send_pct, input int recv_pct,
                           input logic [CountW-1:0] db, input logic [CountW-1:0] lp,
                           input logic [CountW-1:0] rp, input int n_ticks,
                           input bit poke_unused);
    wait_drained();
    repeat (4) @(posedge clk_i);
    write_timing_reg(CFG_DEBOUNCE, db);
    write_timing_reg(CFG_LONG_PRESS, lp);
    write_timing_reg(CFG_REPEAT, rp);
    if (poke_unused) write_timing_reg(CFG_UNUSED, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n_ticks; i++) begin
      scan_ticks.push_back(next_levels());
      // stop queuing ticks until every event so far is out
      if (i % 20 == 19) wait_drained();
    end
  endtask

  initial begin : stimulus
    logic [LevelW-1:0] directed [$];
    directed = '{6'h3F, 6'h00, 6'h3F, 6'h3F, 6'h00, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h00,
                 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h15, 6'h2A, 6'h00, 6'h01, 6'h21,
                 6'h20, 6'h00};
    reset_keys();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: bounce, all keys at once, long press, repeat, split releases
    run_phase(30, 73, 16'd1, 16'd2, 16'd1, 0, 1'b1);
    foreach (directed[i]) scan_ticks.push_back(directed[i]);

    run_phase(30, 73, 16'd2, 16'd5, 16'd3, 30, 1'b0);
    run_phase(73, 30, 16'd1, 16'd1, 16'd1, 30, 1'b1);
    // zero reload acts as a full 16-bit count
    run_phase(0, 0, 16'd3, 16'd4, 16'd0, 20, 1'b0);
    run_phase(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (pending_events.size() != 0)
      report_error($sformatf("%0d events never came out", pending_events.size()));
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
